[design/i2cmbe_pkg.sv]
`timescale 1ns / 1ps
// i2cmbe_pkg: shared types and constants of the i2c master byte engine
// no dependencies; imported by the front end, the sequencer, the top level and the testbench

package i2cmbe_pkg;

    // command codes as they arrive on the command field
    localparam logic [2:0] OP_IDLE  = 3'd0;
    localparam logic [2:0] OP_START = 3'd1;
    localparam logic [2:0] OP_STOP  = 3'd2;
    localparam logic [2:0] OP_WRITE = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    // item classes assigned by the front end
    localparam logic [1:0] KIND_NOP  = 2'd0;
    localparam logic [1:0] KIND_TICK = 2'd1;
    localparam logic [1:0] KIND_CMD  = 2'd2;

    // phase codes inside one bit slot
    localparam logic [1:0] PH_0 = 2'd0;
    localparam logic [1:0] PH_1 = 2'd1;
    localparam logic [1:0] PH_2 = 2'd2;

    // bit slot index: msb first, the ack slot follows bit 0
    localparam logic [3:0] BIT_MSB  = 4'd7;
    localparam logic [3:0] ACK_SLOT = 4'd8;

    // configuration
    localparam logic [15:0] HBT_RESET = 16'd5;
    localparam int          ADDR_W    = 3;
    localparam logic        REG_HBT   = 1'b0;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] op;
        logic [7:0] tx_byte;
        logic       rd_ack;
        logic       sda_level;
    } cmd_item_t;

    typedef struct packed {
        logic       scl_release;
        logic       sda_release;
        logic       busy;
        logic       done;
        logic [7:0] rx_byte;
        logic       ack_seen;
        logic       rejected;
    } result_t;

endpackage

[design/i2cmbe_fifo.sv]
`timescale 1ns / 1ps
// i2cmbe_fifo: small show-ahead queue of registers
// no package dependencies; used by the front end and the sequencer

module i2cmbe_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CNT_FULL);
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[design/i2cmbe_front.sv]
`timescale 1ns / 1ps
// i2cmbe_front: accepts items, classifies them and queues them for the sequencer
// depends on i2cmbe_pkg and i2cmbe_fifo

module i2cmbe_front #(
    parameter int DEPTH = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [2:0]            command,
    input  logic [7:0]            tx_byte,
    input  logic                  rd_ack,
    input  logic                  sda_level,
    input  logic                  item_pop,
    output i2cmbe_pkg::cmd_item_t item,
    output logic                  item_empty
);
    import i2cmbe_pkg::*;

    cmd_item_t                   in_item;
    logic [$bits(cmd_item_t)-1:0] q_rd;

    // tick, real command or unknown code (no-op)
    always_comb
    begin
        in_item.op        = command;
        in_item.tx_byte   = tx_byte;
        in_item.rd_ack    = rd_ack;
        in_item.sda_level = sda_level;
        case (command)
            OP_IDLE:  in_item.kind = KIND_TICK;
            OP_START: in_item.kind = KIND_CMD;
            OP_STOP:  in_item.kind = KIND_CMD;
            OP_WRITE: in_item.kind = KIND_CMD;
            OP_READ:  in_item.kind = KIND_CMD;
            default:  in_item.kind = KIND_NOP;
        endcase
    end

    i2cmbe_fifo #(
        .WIDTH ($bits(cmd_item_t)),
        .DEPTH (DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (in_item),
        .full    (full),
        .pop     (item_pop),
        .rd_data (q_rd),
        .empty   (item_empty)
    );

    assign item = cmd_item_t'(q_rd);

endmodule

[design/i2cmbe_back.sv]
`timescale 1ns / 1ps
// i2cmbe_back: scl/sda bit sequencer, phase timer and result queue
// depends on i2cmbe_pkg and i2cmbe_fifo

module i2cmbe_back #(
    parameter int DEPTH = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [15:0]           half_bit_ticks,
    input  i2cmbe_pkg::cmd_item_t item,
    input  logic                  item_empty,
    output logic                  item_pop,
    input  logic                  res_pop,
    output i2cmbe_pkg::result_t   res,
    output logic                  res_empty
);
    import i2cmbe_pkg::*;

    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic [2:0]  op_reg, op_next;
    logic [1:0]  phase_reg, phase_next;
    logic [3:0]  bit_reg, bit_next;
    logic [7:0]  shift_reg, shift_next;
    logic [15:0] tick_reg, tick_next;
    logic        ack_reg, ack_next;
    logic [7:0]  rx_reg, rx_next;
    logic        ack_out_reg, ack_out_next;

    logic        take, res_full;
    logic        done, rej, fin, adv_bit;
    logic [15:0] limit, tick_inc;
    logic [2:0]  bit_dec;
    result_t     res_in;
    logic [$bits(result_t)-1:0] q_rd;

    assign take     = !item_empty && !res_full;
    assign item_pop = take;
    assign limit    = (half_bit_ticks == '0) ? 16'd1 : half_bit_ticks;
    assign tick_inc = tick_reg + 16'd1;
    assign bit_dec  = bit_reg[2:0] - 3'd1;

    always_comb
    begin
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        op_next      = op_reg;
        phase_next   = phase_reg;
        bit_next     = bit_reg;
        shift_next   = shift_reg;
        tick_next    = tick_reg;
        ack_next     = ack_reg;
        rx_next      = rx_reg;
        ack_out_next = ack_out_reg;
        done         = 1'b0;
        rej          = 1'b0;
        fin          = 1'b0;
        adv_bit      = 1'b0;
        if (take)
        begin
            case (item.kind)
                KIND_CMD:
                begin
                    if (op_reg != OP_IDLE)
                    begin
                        rej = 1'b1;
                    end
                    else
                    begin
                        op_next    = item.op;
                        phase_next = PH_0;
                        bit_next   = BIT_MSB;
                        tick_next  = '0;
                        case (item.op)
                            OP_START:
                            begin
                                sda_next = 1'b1;
                                scl_next = 1'b1;
                            end
                            OP_STOP:
                            begin
                                sda_next = 1'b0;
                            end
                            OP_WRITE:
                            begin
                                shift_next = item.tx_byte;
                                sda_next   = item.tx_byte[7];
                            end
                            default:
                            begin
                                shift_next   = '0;
                                ack_out_next = item.rd_ack;
                                sda_next     = 1'b1;
                            end
                        endcase
                    end
                end
                KIND_TICK:
                begin
                    if (op_reg != OP_IDLE)
                    begin
                        if ((tick_inc >= limit) || (tick_inc == '0))
                        begin
                            tick_next = '0;
                            case (op_reg)
                                OP_START:
                                begin
                                    if (phase_reg == PH_0)
                                    begin
                                        sda_next   = 1'b0;
                                        phase_next = PH_1;
                                    end
                                    else if (phase_reg == PH_1)
                                    begin
                                        scl_next   = 1'b0;
                                        phase_next = PH_2;
                                    end
                                    else
                                    begin
                                        fin = 1'b1;
                                    end
                                end
                                OP_STOP:
                                begin
                                    if (phase_reg == PH_0)
                                    begin
                                        scl_next   = 1'b1;
                                        phase_next = PH_1;
                                    end
                                    else if (phase_reg == PH_1)
                                    begin
                                        sda_next   = 1'b1;
                                        phase_next = PH_2;
                                    end
                                    else
                                    begin
                                        fin = 1'b1;
                                    end
                                end
                                OP_WRITE:
                                begin
                                    if (phase_reg == PH_0)
                                    begin
                                        scl_next   = 1'b1;
                                        phase_next = PH_1;
                                    end
                                    else if (phase_reg == PH_1)
                                    begin
                                        // slave ack: sda pulled low while scl high
                                        if ((bit_reg == ACK_SLOT) && scl_reg)
                                        begin
                                            ack_next = !item.sda_level;
                                        end
                                        scl_next   = 1'b0;
                                        phase_next = PH_2;
                                    end
                                    else if (bit_reg == ACK_SLOT)
                                    begin
                                        fin = 1'b1;
                                    end
                                    else
                                    begin
                                        adv_bit = 1'b1;
                                    end
                                end
                                OP_READ:
                                begin
                                    if (phase_reg == PH_0)
                                    begin
                                        scl_next   = 1'b1;
                                        phase_next = PH_1;
                                    end
                                    else if (bit_reg == ACK_SLOT)
                                    begin
                                        if (phase_reg == PH_1)
                                        begin
                                            scl_next   = 1'b0;
                                            phase_next = PH_2;
                                        end
                                        else
                                        begin
                                            sda_next = 1'b1;
                                            rx_next  = shift_reg;
                                            fin      = 1'b1;
                                        end
                                    end
                                    else
                                    begin
                                        if (scl_reg && item.sda_level)
                                        begin
                                            shift_next[bit_reg[2:0]] = 1'b1;
                                        end
                                        scl_next = 1'b0;
                                        adv_bit  = 1'b1;
                                    end
                                end
                                default:
                                begin
                                    op_next    = OP_IDLE;
                                    phase_next = PH_0;
                                    bit_next   = BIT_MSB;
                                end
                            endcase
                            if (adv_bit)
                            begin
                                phase_next = PH_0;
                                if (bit_reg == '0)
                                begin
                                    bit_next = ACK_SLOT;
                                    sda_next = (op_reg == OP_WRITE) ? 1'b1 : !ack_out_reg;
                                end
                                else
                                begin
                                    bit_next = {1'b0, bit_dec};
                                    if (op_reg == OP_WRITE)
                                    begin
                                        sda_next = shift_reg[bit_dec];
                                    end
                                end
                            end
                            if (fin)
                            begin
                                done       = 1'b1;
                                op_next    = OP_IDLE;
                                phase_next = PH_0;
                                bit_next   = BIT_MSB;
                            end
                        end
                        else
                        begin
                            tick_next = tick_inc;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
            op_reg      <= OP_IDLE;
            phase_reg   <= PH_0;
            bit_reg     <= BIT_MSB;
            shift_reg   <= '0;
            tick_reg    <= '0;
            ack_reg     <= 1'b0;
            rx_reg      <= '0;
            ack_out_reg <= 1'b0;
        end
        else
        begin
            scl_reg     <= scl_next;
            sda_reg     <= sda_next;
            op_reg      <= op_next;
            phase_reg   <= phase_next;
            bit_reg     <= bit_next;
            shift_reg   <= shift_next;
            tick_reg    <= tick_next;
            ack_reg     <= ack_next;
            rx_reg      <= rx_next;
            ack_out_reg <= ack_out_next;
        end
    end

    always_comb
    begin
        res_in.scl_release = scl_next;
        res_in.sda_release = sda_next;
        res_in.busy        = (op_next != OP_IDLE);
        res_in.done        = done;
        res_in.rx_byte     = rx_next;
        res_in.ack_seen    = ack_next;
        res_in.rejected    = rej;
    end

    i2cmbe_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (take),
        .wr_data (res_in),
        .full    (res_full),
        .pop     (res_pop),
        .rd_data (q_rd),
        .empty   (res_empty)
    );

    assign res = result_t'(q_rd);

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (op_reg == OP_IDLE) |-> (phase_reg == PH_0 && tick_reg == '0 && bit_reg == BIT_MSB))
        else $error("idle sequencer left phase, timer or bit index dirty");

    a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (take && done) |=> (op_reg == OP_IDLE))
        else $error("completed command left the sequencer busy");

    a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (take && rej) |=> ($stable(op_reg) && op_reg != OP_IDLE))
        else $error("rejected command disturbed the active command");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != 2'd3) && (bit_reg <= ACK_SLOT))
        else $error("phase or bit index out of range");

    a_no_tick_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (take && item.kind == KIND_TICK && op_reg == OP_IDLE) |=> $stable(scl_reg)
            && $stable(sda_reg))
        else $error("tick moved the lines while idle");

endmodule

[design/i2c_master_byte_engine_core.sv]
`timescale 1ns / 1ps
// i2c master byte engine, top level: apb register, front end and sequencer
// a result passes through the command queue and the result queue registers before it is on the result ports
// throughput: one item per clock while neither queue stalls; each beat is one sequencer step, no loop spans cycles
// both sides are queues (depth CMD_Q_DEPTH and RES_Q_DEPTH) so either side may stall
// reset (rst_n low, async) empties both queues, releases scl and sda, returns to idle
// and sets half_bit_ticks to 5; no clearing pass is needed

module i2c_master_byte_engine_core #(
    parameter int CMD_Q_DEPTH = 2,
    parameter int RES_Q_DEPTH = 2
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [i2cmbe_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // item side
    input  logic                        push,
    output logic                        full,
    input  logic [2:0]                  command,
    input  logic [7:0]                  tx_byte,
    input  logic                        rd_ack,
    input  logic                        sda_level,
    // result side
    output logic                        empty,
    input  logic                        pop,
    output logic                        scl_release,
    output logic                        sda_release,
    output logic                        busy_res,
    output logic                        done_res,
    output logic [7:0]                  rx_byte,
    output logic                        ack_seen,
    output logic                        rejected
);
    import i2cmbe_pkg::*;

    logic [15:0] hbt_reg, hbt_next;
    logic        cfg_wr;
    cmd_item_t   item;
    logic        item_empty;
    logic        item_pop;
    result_t     res;

    // apb: zero wait states, single register in the low word
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_HBT) ? {16'b0, hbt_reg} : 32'b0;

    always_comb
    begin
        hbt_next = hbt_reg;
        if (cfg_wr && (paddr[2] == REG_HBT))
        begin
            hbt_next = pwdata[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hbt_reg <= HBT_RESET;
        end
        else
        begin
            hbt_reg <= hbt_next;
        end
    end

    // front end: classify tick / command / no-op and buffer the beat
    i2cmbe_front #(
        .DEPTH (CMD_Q_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .command    (command),
        .tx_byte    (tx_byte),
        .rd_ack     (rd_ack),
        .sda_level  (sda_level),
        .item_pop   (item_pop),
        .item       (item),
        .item_empty (item_empty)
    );

    // back end: one sequencer step per beat, result queued toward the consumer
    i2cmbe_back #(
        .DEPTH (RES_Q_DEPTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .half_bit_ticks (hbt_reg),
        .item           (item),
        .item_empty     (item_empty),
        .item_pop       (item_pop),
        .res_pop        (pop),
        .res            (res),
        .res_empty      (empty)
    );

    assign scl_release = res.scl_release;
    assign sda_release = res.sda_release;
    assign busy_res    = res.busy;
    assign done_res    = res.done;
    assign rx_byte     = res.rx_byte;
    assign ack_seen    = res.ack_seen;
    assign rejected    = res.rejected;

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// testbench for i2c_master_byte_engine_core: random and directed command/tick beats,
// with a line-level model of the sequencer predicting every result beat
// depends on i2cmbe_pkg and i2c_master_byte_engine_core

module testbench;
    import i2cmbe_pkg::*;

    // tick beats carry the idle command code
    localparam logic [2:0]        CMD_TICK = OP_IDLE;
    localparam logic [ADDR_W-1:0] HBT_ADDR = ADDR_W'(4 * REG_HBT);

    // predicts scl/sda drive, status and captured bytes after every beat
    class i2c_line_scoreboard;
        logic [15:0] period;
        logic        scl, sda, ack, ack_choice;
        logic [2:0]  op;
        logic [1:0]  ph;
        logic [3:0]  bit_idx;
        logic [7:0]  shreg, rx_last;
        logic [15:0] tcount;
        result_t     due_lines[$];
        int          errors, n_checked, n_commands, n_rejected, n_done;

        function new();
            period = HBT_RESET;
            scl = 1'b1;
            sda = 1'b1;
            ack = 1'b0;
            ack_choice = 1'b0;
            shreg = '0;
            rx_last = '0;
            op = OP_IDLE;
            ph = PH_0;
            bit_idx = BIT_MSB;
            tcount = '0;
        endfunction

        function bit engine_busy();
            return op != OP_IDLE;
        endfunction

        function int waiting();
            return due_lines.size();
        endfunction

        function void set_period(logic [15:0] value);
            period = value;
        endfunction

        // move to the next bit slot; after bit 0 comes the ack slot
        function void advance_bit();
            ph = PH_0;
            if (bit_idx == 4'd0) begin
                bit_idx = ACK_SLOT;
                sda = (op == OP_WRITE) ? 1'b1 : !ack_choice;
            end else begin
                bit_idx = {1'b0, bit_idx[2:0] - 3'd1};
                if (op == OP_WRITE)
                    sda = shreg[bit_idx[2:0]];
            end
        endfunction

        // end of one half period; returns 1 when the command completes
        function bit phase_end(logic sda_in);
            case (op)
                OP_START: begin
                    if (ph == PH_0) begin sda = 1'b0; ph = PH_1; end
                    else if (ph == PH_1) begin scl = 1'b0; ph = PH_2; end
                    else return 1'b1;
                end
                OP_STOP: begin
                    if (ph == PH_0) begin scl = 1'b1; ph = PH_1; end
                    else if (ph == PH_1) begin sda = 1'b1; ph = PH_2; end
                    else return 1'b1;
                end
                OP_WRITE: begin
                    if (ph == PH_0) begin
                        scl = 1'b1;
                        ph = PH_1;
                    end else if (ph == PH_1) begin
                        if (bit_idx == ACK_SLOT && scl)
                            ack = !sda_in;
                        scl = 1'b0;
                        ph = PH_2;
                    end else if (bit_idx == ACK_SLOT) begin
                        return 1'b1;
                    end else begin
                        advance_bit();
                    end
                end
                OP_READ: begin
                    if (ph == PH_0) begin
                        scl = 1'b1;
                        ph = PH_1;
                    end else if (bit_idx == ACK_SLOT) begin
                        if (ph == PH_1) begin
                            scl = 1'b0;
                            ph = PH_2;
                        end else begin
                            sda = 1'b1;
                            rx_last = shreg;
                            return 1'b1;
                        end
                    end else begin
                        if (scl)
                            shreg[bit_idx[2:0]] = shreg[bit_idx[2:0]] | sda_in;
                        scl = 1'b0;
                        advance_bit();
                    end
                end
                default: begin
                    op = OP_IDLE;
                    ph = PH_0;
                    bit_idx = BIT_MSB;
                    tcount = '0;
                end
            endcase
            return 1'b0;
        endfunction

        // accepted input beat: update the model and queue the result it causes
        function void take_item(logic [2:0] cmd, logic [7:0] tx, logic sa, logic sda_in);
            logic        rej, fin;
            logic [15:0] lim;
            result_t     r;
            rej = 1'b0;
            fin = 1'b0;
            if (cmd >= OP_START && cmd <= OP_READ) begin
                if (op != OP_IDLE) begin
                    rej = 1'b1;
                    n_rejected++;
                end else begin
                    n_commands++;
                    op = cmd;
                    ph = PH_0;
                    bit_idx = BIT_MSB;
                    tcount = '0;
                    case (cmd)
                        OP_START: begin sda = 1'b1; scl = 1'b1; end
                        OP_STOP:  sda = 1'b0;
                        OP_WRITE: begin shreg = tx; sda = tx[7]; end
                        default:  begin shreg = '0; ack_choice = sa; sda = 1'b1; end
                    endcase
                end
            end else if (cmd == CMD_TICK && op != OP_IDLE) begin
                lim = (period == '0) ? 16'd1 : period;
                tcount = tcount + 16'd1;
                if (tcount >= lim || tcount == '0) begin
                    tcount = '0;
                    if (phase_end(sda_in)) begin
                        fin = 1'b1;
                        n_done++;
                        op = OP_IDLE;
                        ph = PH_0;
                        bit_idx = BIT_MSB;
                        tcount = '0;
                    end
                end
            end
            r.scl_release = scl;
            r.sda_release = sda;
            r.busy        = (op != OP_IDLE);
            r.done        = fin;
            r.rx_byte     = rx_last;
            r.ack_seen    = ack;
            r.rejected    = rej;
            due_lines.push_back(r);
        endfunction

        function void cmp(string what, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            end
        endfunction

        // accepted result beat against the oldest prediction
        function void check_lines(result_t got);
            result_t want;
            if (due_lines.size() == 0) begin
                errors++;
                $display("%0t ns: result beat with nothing expected, expected none, actual %0h",
                         $time, got);
                return;
            end
            want = due_lines.pop_front();
            n_checked++;
            cmp("scl_release", want.scl_release, got.scl_release);
            cmp("sda_release", want.sda_release, got.sda_release);
            cmp("busy_res", want.busy, got.busy);
            cmp("done_res", want.done, got.done);
            cmp("rx_byte", want.rx_byte, got.rx_byte);
            cmp("ack_seen", want.ack_seen, got.ack_seen);
            cmp("rejected", want.rejected, got.rejected);
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              push = 1'b0;
    logic              full;
    logic [2:0]        command = CMD_TICK;
    logic [7:0]        tx_byte = '0;
    logic              rd_ack = 1'b0;
    logic              sda_level = 1'b1;
    logic              empty;
    logic              pop = 1'b0;
    logic              scl_release, sda_release, busy_res, done_res, ack_seen, rejected;
    logic [7:0]        rx_byte;

    i2c_line_scoreboard sb = new();

    int  items_left;        // beat budget of the current phase
    int  n_items;
    int  n_writes;
    int  pop_gap;
    bit  quiet;             // no idling on either side
    int  reg_errors;

    // half periods per phase: extremes, zero, and a mid-phase jump down from the max
    logic [15:0] hbt_plan[7] = '{16'd1, 16'd0, 16'd3, 16'd65535, 16'd2, 16'd4, 16'd1};

    i2c_master_byte_engine_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .push        (push),
        .full        (full),
        .command     (command),
        .tx_byte     (tx_byte),
        .rd_ack      (rd_ack),
        .sda_level   (sda_level),
        .empty       (empty),
        .pop         (pop),
        .scl_release (scl_release),
        .sda_release (sda_release),
        .busy_res    (busy_res),
        .done_res    (done_res),
        .rx_byte     (rx_byte),
        .ack_seen    (ack_seen),
        .rejected    (rejected)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // result side: pop with random stall bursts
    always @(posedge clk)
    begin
        if (!rst_n) begin
            pop <= 1'b0;
        end else if (pop_gap > 0) begin
            pop_gap <= pop_gap - 1;
            pop <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            pop_gap <= $urandom_range(0, 8);
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
        end
    end

    // result beat taken at this edge: check it (pre-edge values)
    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && pop && !empty) begin
            got.scl_release = scl_release;
            got.sda_release = sda_release;
            got.busy        = busy_res;
            got.done        = done_res;
            got.rx_byte     = rx_byte;
            got.ack_seen    = ack_seen;
            got.rejected    = rejected;
            sb.check_lines(got);
        end
    end

    // one input beat; push stays high into the next call unless a gap is drawn
    task automatic send_item(input logic [2:0] cmd, input logic [7:0] tx,
                             input logic sa, input logic sda_in);
        int gap;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 9);
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push      <= 1'b1;
        command   <= cmd;
        tx_byte   <= tx;
        rd_ack    <= sa;
        sda_level <= sda_in;
        do @(posedge clk); while (full);
        sb.take_item(cmd, tx, sa, sda_in);
        items_left--;
        n_items++;
    endtask

    // tick beat with random line level and don't-care fields
    task automatic tick();
        send_item(CMD_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
    endtask

    // stop pushing and wait for every predicted result beat
    task automatic settle();
        push <= 1'b0;
        while (sb.waiting() > 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // apb write: setup cycle, then access cycle where the register takes the value
    task automatic cfg_write(input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= HBT_ADDR;
        pwdata  <= {16'h0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.set_period(value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // apb read and compare with the model's copy of the register
    task automatic cfg_readback();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= HBT_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== {16'h0, sb.period}) begin
            reg_errors++;
            $display("%0t ns: half_bit_ticks readback mismatch, expected %0h, actual %0h",
                     $time, {16'h0, sb.period}, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // tick the running command to completion, with stray commands mixed in
    task automatic finish_command();
        int roll;
        while (sb.engine_busy() && items_left > 0) begin
            roll = $urandom_range(0, 99);
            if (roll < 4)
                send_item(3'($urandom_range(OP_START, OP_READ)), 8'($urandom),
                          1'($urandom), 1'($urandom));
            else if (roll < 7)
                send_item(3'($urandom_range(OP_READ + 1, 7)), 8'($urandom),
                          1'($urandom), 1'($urandom));
            else
                tick();
        end
    endtask

    task automatic issue(input logic [2:0] cmd, input logic [7:0] tx, input logic sa);
        if (items_left <= 0)
            return;
        send_item(cmd, tx, sa, 1'($urandom));
        finish_command();
    endtask

    // start, one to three byte transfers, stop; first writes use the byte extremes
    task automatic bus_transaction();
        int         nbytes;
        logic [7:0] b;
        nbytes = $urandom_range(1, 3);
        issue(OP_START, 8'($urandom), 1'($urandom));
        repeat (nbytes) begin
            if ($urandom_range(0, 1) == 0) begin
                b = (n_writes == 0) ? 8'h00 : (n_writes == 1) ? 8'hFF : 8'($urandom);
                n_writes++;
                issue(OP_WRITE, b, 1'($urandom));
            end else begin
                issue(OP_READ, 8'($urandom), 1'($urandom));
            end
        end
        issue(OP_STOP, 8'($urandom), 1'($urandom));
    endtask

    // mostly well-formed transactions, some noise beats with any code
    task automatic random_traffic(input int budget);
        items_left = budget;
        while (items_left > 0) begin
            if (sb.engine_busy())
                finish_command();
            else if ($urandom_range(0, 9) < 2)
                send_item(3'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
            else
                bus_transaction();
        end
    endtask

    initial
    begin
        int k;
        items_left = 1000;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register comes out of reset at its default
        cfg_readback();
        @(posedge clk);

        foreach (hbt_plan[p]) begin
            quiet = (p == $size(hbt_plan) - 1);
            cfg_write(hbt_plan[p]);
            @(posedge clk);
            cfg_readback();
            @(posedge clk);
            if (p == 0) begin
                // directed: idle tick, unknown codes, busy rejection of write and read, start/stop
                items_left = 1000;
                tick();
                for (k = 1; k <= 3; k++)
                    send_item(3'(OP_READ + k), 8'hFF, 1'b1, 1'b0);
                send_item(OP_START, 8'h00, 1'b0, 1'b1);
                send_item(OP_WRITE, 8'hFF, 1'b1, 1'b1);
                repeat (3) tick();
                send_item(OP_STOP, 8'hFF, 1'b0, 1'b0);
                send_item(OP_READ, 8'h00, 1'b1, 1'b1);
                repeat (3) tick();
                tick();
                random_traffic(100);
            end else if (hbt_plan[p] == 16'hFFFF) begin
                // max half period: start a command, leave it mid-phase
                items_left = 100;
                if (!sb.engine_busy())
                    send_item(OP_START, 8'($urandom), 1'($urandom), 1'($urandom));
                repeat (6) tick();
            end else begin
                random_traffic(105);
            end
            settle();
        end

        repeat (4) @(posedge clk);
        $display("covered %0d input beats, %0d result beats checked, %0d commands run",
                 n_items, sb.n_checked, sb.n_commands);
        $display("%0d commands completed, %0d rejected while busy, half periods 0 to 65535",
                 sb.n_done, sb.n_rejected);
        if (sb.errors == 0 && reg_errors == 0 && sb.waiting() == 0)
            $display("** i2c_master_byte_engine_core: PASSED **");
        else
            $display("** i2c_master_byte_engine_core: FAILED **");
        $finish;
    end

    // hang guard
    initial
    begin
        #5_000_000;
        $display("** i2c_master_byte_engine_core: FAILED **");
        $finish;
    end

endmodule
